FILE: sv/vertex_transform_4x4_macros.svh
// Assertion macros shared by the vertex transform RTL.
// Included by modules that check their own pipeline behavior; no other dependencies.
`ifndef VERTEX_TRANSFORM_4X4_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define VT44_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vt44 assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define VT44_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vt44 assertion failed");
`else
`define VT44_ASSERT_NOW(label, clk, rst, ante, cons)
`define VT44_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/vt44_pkg.sv
// Package for the vertex transform: fixed-point widths, limits and status codes.
// No dependencies; imported by every module of the block.
`default_nettype none
package vt44_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int NUM_W     = ELEM_W + FRAC_BITS;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NREG      = 8;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  typedef logic signed [ELEM_W-1:0] elem_t;

  localparam elem_t ELEM_ONE = elem_t'(64'sd1 <<< FRAC_BITS);
  localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
  localparam elem_t ELEM_MIN = 32'sh8000_0000;

  // Quotient magnitude limits for the two signs.
  localparam logic [NUM_W-1:0] QLIM_POS = NUM_W'(64'h7FFF_FFFF);
  localparam logic [NUM_W-1:0] QLIM_NEG = NUM_W'(64'h8000_0000);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_WZERO = 2'd2
  } status_t;

  // Side information that travels beside the dividers.
  typedef struct packed {
    logic        point;
    logic        wzero;
    logic        sat;
    logic [2:0]  neg;
    elem_t [2:0] r;
  } meta_t;

endpackage
`default_nettype wire

FILE: sv/vt44_lane.sv
// One matrix column lane: four 32x32 products, then exact sum, shift and saturation.
// Depends on vt44_pkg.
`default_nettype none
module vt44_lane
  import vt44_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire elem_t [3:0] v,
  input  wire elem_t [3:0] m,
  output elem_t            r,
  output logic             sat
);

  localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(ELEM_MAX);
  localparam logic signed [SUM_W-1:0] LIM_LO = SUM_W'(ELEM_MIN);

  logic signed [PROD_W-1:0] prod [4];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sh;

  // Product stage: one multiplier per row element.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod[k] <= PROD_W'(m[k]) * PROD_W'(v[k]);
      end
    end
  end

  // Full-width sum, arithmetic shift back to fixed point.
  always_comb begin
    sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
    sh  = sum >>> FRAC_BITS;
  end

  // Saturation stage.
  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > LIM_HI) begin
        r   <= ELEM_MAX;
        sat <= 1'b1;
      end else if (sh < LIM_LO) begin
        r   <= ELEM_MIN;
        sat <= 1'b1;
      end else begin
        r   <= sh[ELEM_W-1:0];
        sat <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/vt44_divider.sv
// Pipelined restoring divider: one quotient bit per stage, NUM_W stages.
// Depends on vt44_pkg.
`default_nettype none
module vt44_divider
  import vt44_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [ELEM_W-1:0] den,
  output logic      [NUM_W-1:0]  quo
);

  logic [ELEM_W-1:0] rem [NUM_W+1];
  logic [NUM_W-1:0]  nq  [NUM_W+1];
  logic [ELEM_W-1:0] dd  [NUM_W+1];

  assign rem[0] = '0;
  assign nq[0]  = num;
  assign dd[0]  = den;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [ELEM_W:0] part;
    logic            ge;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
      part = {rem[i], nq[i][NUM_W-1]};
      ge   = part >= {1'b0, dd[i]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? ELEM_W'(part - {1'b0, dd[i]}) : part[ELEM_W-1:0];
        nq[i+1]  <= {nq[i][NUM_W-2:0], ge};
        dd[i+1]  <= dd[i];
      end
    end
  end

  assign quo = nq[NUM_W];

endmodule
`default_nettype wire

FILE: sv/vertex_transform_4x4.sv
// Vertex transform top level: register file, four column lanes, three
// dividers and the merging output stage. Depends on vt44_pkg, vt44_lane,
// vt44_divider and vertex_transform_4x4_macros.svh.
// Input transfer to result valid passes the lane product and saturation
// registers, divide setup, the bit-per-stage dividers that set the depth
// and the output register; one vertex per cycle unless the output stalls.
// The whole pipeline stalls while the output holds an untaken result.
// Synchronous reset clears the valid bits and loads the identity matrix.
`default_nettype none
`include "vertex_transform_4x4_macros.svh"
module vertex_transform_4x4
  import vt44_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // Input channel.
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              func,
  input  wire elem_t             in_x,
  input  wire elem_t             in_y,
  input  wire elem_t             in_z,
  // Output channel.
  output logic                   out_valid,
  input  wire logic              out_ready,
  output elem_t                  out_x,
  output elem_t                  out_y,
  output elem_t                  out_z,
  output logic      [1:0]        status
);

  localparam int NSTG = NUM_W + 4;

  logic [DATA_W-1:0] mreg [NREG];
  logic [NSTG-1:0]   vld;
  logic              en;
  logic              pt_a;
  logic              pt_b;
  elem_t [3:0]       vin;
  elem_t [3:0]       r;
  logic  [3:0]       lsat;
  logic [NUM_W-1:0]  num  [3];
  logic [NUM_W-1:0]  quo  [3];
  logic [ELEM_W-1:0] den;
  meta_t             meta [NUM_W+1];
  elem_t [2:0]       res;
  logic  [2:0]       qsat;

  // Register file writes and reads.
  assign pready = 1'b1;
  assign prdata = mreg[paddr[ADDR_W-1:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) begin
        mreg[i] <= '0;
      end
      mreg[0] <= DATA_W'(ELEM_ONE);
      mreg[2] <= DATA_W'(ELEM_ONE) << ELEM_W;
      mreg[5] <= DATA_W'(ELEM_ONE);
      mreg[7] <= DATA_W'(ELEM_ONE) << ELEM_W;
    end else if (psel && penable && pwrite && pready) begin
      mreg[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  // Global pipeline advance: move unless the output holds a result that is not taken.
  assign en       = !vld[NSTG-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // Homogeneous input row vector.
  assign vin[0] = in_x;
  assign vin[1] = in_y;
  assign vin[2] = in_z;
  assign vin[3] = func ? elem_t'(0) : ELEM_ONE;

  always_ff @(posedge clk) begin
    if (en) begin
      pt_a <= !func;
      pt_b <= pt_a;
    end
  end

  // Four column lanes.
  for (genvar c = 0; c < 4; c++) begin : g_lane
    elem_t [3:0] mcol;
    for (genvar k = 0; k < 4; k++) begin : g_row
      assign mcol[k] = mreg[2*k + c/2][(c%2)*ELEM_W +: ELEM_W];
    end
    vt44_lane u_lane (
      .clk (clk),
      .en  (en),
      .v   (vin),
      .m   (mcol),
      .r   (r[c]),
      .sat (lsat[c])
    );
  end

  // Divide setup: magnitudes and quotient signs.
  always_ff @(posedge clk) begin
    if (en) begin
      den <= r[3][ELEM_W-1] ? ELEM_W'(-r[3]) : ELEM_W'(r[3]);
      meta[0].point <= pt_b;
      meta[0].wzero <= pt_b && (r[3] == '0);
      meta[0].sat   <= lsat[0] | lsat[1] | lsat[2] | (pt_b & lsat[3]);
      for (int c = 0; c < 3; c++) begin
        num[c] <= {(r[c][ELEM_W-1] ? ELEM_W'(-r[c]) : ELEM_W'(r[c])),
                   FRAC_BITS'(0)};
        meta[0].neg[c] <= r[c][ELEM_W-1] ^ r[3][ELEM_W-1];
        meta[0].r[c]   <= r[c];
      end
    end
  end

  // Side information runs beside the divider stages.
  for (genvar i = 0; i < NUM_W; i++) begin : g_meta
    always_ff @(posedge clk) begin
      if (en) begin
        meta[i+1] <= meta[i];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    vt44_divider u_div (
      .clk (clk),
      .en  (en),
      .num (num[c]),
      .den (den),
      .quo (quo[c])
    );

    // Sign and saturate each quotient.
    always_comb begin
      qsat[c] = 1'b0;
      if (meta[NUM_W].neg[c]) begin
        if (quo[c] > QLIM_NEG) begin
          res[c]  = ELEM_MIN;
          qsat[c] = 1'b1;
        end else begin
          res[c] = ELEM_W'(-quo[c]);
        end
      end else begin
        if (quo[c] > QLIM_POS) begin
          res[c]  = ELEM_MAX;
          qsat[c] = 1'b1;
        end else begin
          res[c] = quo[c][ELEM_W-1:0];
        end
      end
    end
  end

  // Merging output stage.
  always_ff @(posedge clk) begin
    if (en) begin
      if (meta[NUM_W].wzero) begin
        out_x  <= '0;
        out_y  <= '0;
        out_z  <= '0;
        status <= ST_WZERO;
      end else if (!meta[NUM_W].point) begin
        out_x  <= meta[NUM_W].r[0];
        out_y  <= meta[NUM_W].r[1];
        out_z  <= meta[NUM_W].r[2];
        status <= meta[NUM_W].sat ? ST_SAT : ST_OK;
      end else begin
        out_x  <= res[0];
        out_y  <= res[1];
        out_z  <= res[2];
        status <= (meta[NUM_W].sat || (qsat != '0)) ? ST_SAT : ST_OK;
      end
    end
  end

  // A transfer in always enters the first stage.
  `VT44_ASSERT_NEXT(a_enter, clk, rst, in_valid && in_ready, vld[0])
  // A stalled pipeline keeps every item in place.
  `VT44_ASSERT_NEXT(a_hold, clk, rst, !en, $stable(vld))
  // A zero w result carries all-zero coordinates.
  `VT44_ASSERT_NOW(a_wzero, clk, rst, out_valid && (status == ST_WZERO),
                   (out_x == '0) && (out_y == '0) && (out_z == '0))

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for vertex_transform_4x4: APB matrix setup, random vertex
// transfers with idle gaps, and a scoreboard fed by a fixed-point transform predictor.
// Depends on vt44_pkg and the vertex_transform_4x4 RTL.
`default_nettype none
module tb;
  import vt44_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic  func;
    elem_t x;
    elem_t y;
    elem_t z;
  } vertex_t;

  typedef struct packed {
    elem_t      x;
    elem_t      y;
    elem_t      z;
    logic [1:0] st;
  } xform_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  elem_t in_x = '0, in_y = '0, in_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  elem_t out_x, out_y, out_z;
  logic [1:0] status;
  // Whether the driven item was taken at the last rising edge.
  logic in_ready_q = 1'b0;

  vertex_transform_4x4 dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor copy of the matrix registers.
  logic [63:0] matrix_regs [NREG];
  vertex_t pending_vertices[$];
  xform_t  expected_xforms[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int n_sat = 0, n_wzero = 0;
  int idle_cycles = 0;
  int in_gap = 0, out_gap = 0;

  function automatic logic signed [63:0] sat_elem(logic signed [63:0] v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Row vector times matrix, shift, saturate, then optional perspective divide.
  function automatic xform_t transform_vertex(vertex_t vin);
    logic signed [63:0] v [4];
    logic signed [63:0] r [4];
    logic signed [SUM_W-1:0] acc;
    logic signed [31:0] m;
    logic signed [63:0] num, q;
    logic sat;
    xform_t res;
    sat = 1'b0;
    v[0] = vin.x;
    v[1] = vin.y;
    v[2] = vin.z;
    v[3] = vin.func ? 64'sd0 : (64'sd1 <<< FRAC_BITS);
    for (int c = 0; c < 4; c++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        m = (c & 1) ? matrix_regs[2*k + c/2][63:32] : matrix_regs[2*k + c/2][31:0];
        acc = acc + SUM_W'(m * v[k]);
      end
      acc = acc >>> FRAC_BITS;
      if (acc > 66'sd2147483647) r[c] = 64'sd2147483648;
      else if (acc < -66'sd2147483648) r[c] = -64'sd2147483649;
      else r[c] = 64'(acc);
    end
    for (int c = 0; c < 3; c++) r[c] = sat_elem(r[c], sat);
    if (!vin.func) begin
      r[3] = sat_elem(r[3], sat);
      if (r[3] == 0) begin
        res.x = '0;
        res.y = '0;
        res.z = '0;
        res.st = ST_WZERO;
        return res;
      end
      for (int c = 0; c < 3; c++) begin
        num = r[c] <<< FRAC_BITS;
        q = num / r[3];
        r[c] = sat_elem(q, sat);
      end
    end
    res.x = r[0][31:0];
    res.y = r[1][31:0];
    res.z = r[2][31:0];
    res.st = sat ? ST_SAT : ST_OK;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
    errors++;
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic apb_write(int idx, logic [63:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * idx);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    matrix_regs[idx] = data;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [31:0] rand_elem(int kind);
    case (kind)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'h0000_0000;
      4: return $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h7FFFF)) :
                                       -32'($urandom_range(0, 32'h7FFFF));
      default: return $urandom();
    endcase
  endfunction

  // Random matrix: small elements, or with wide set a mix of extremes and full-range values.
  task automatic load_random_matrix(bit wide);
    logic [31:0] lo, hi;
    for (int i = 0; i < NREG; i++) begin
      lo = wide ? rand_elem($urandom_range(0, 5)) : rand_elem(4);
      hi = wide ? rand_elem($urandom_range(0, 5)) : rand_elem(4);
      apb_write(i, {hi, lo});
    end
  endtask

  // Wait until every queued, driven and in-flight item has come back.
  task automatic wait_drained;
    while (pending_vertices.size() != 0 || in_valid || expected_xforms.size() != 0)
      @(posedge clk);
    repeat (NUM_W + 10) @(posedge clk);
  endtask

  task automatic push_vertex(logic f, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vertex_t vtx;
    vtx.func = f;
    vtx.x = x;
    vtx.y = y;
    vtx.z = z;
    pending_vertices.push_back(vtx);
  endtask

  task automatic random_batch(int n);
    for (int i = 0; i < n; i++)
      push_vertex(1'($urandom_range(0, 1)), rand_elem($urandom_range(0, 7)),
                  rand_elem($urandom_range(0, 7)), rand_elem($urandom_range(0, 7)));
  endtask

  // Input driver: changes at the falling edge, holds until the transfer.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready_q) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_vertices.size() != 0) begin
      in_valid <= 1'b1;
      func <= pending_vertices[0].func;
      in_x <= pending_vertices[0].x;
      in_y <= pending_vertices[0].y;
      in_z <= pending_vertices[0].z;
      pending_vertices.pop_front();
      in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12) * ($urandom_range(0, 1));
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Input transfers feed the predictor.
  always @(posedge clk) begin
    in_ready_q <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      expected_xforms.push_back(transform_vertex({func, in_x, in_y, in_z}));
      sent++;
    end
  end

  // Output stall pattern.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready)
        out_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin
    xform_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_xforms.size() == 0) begin
        report_mismatch("unexpected result", out_x, 32'd0);
      end else begin
        want = expected_xforms.pop_front();
        if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
        if (status !== want.st) report_mismatch("status", 32'(status), 32'(want.st));
        if (want.st == ST_SAT) n_sat++;
        if (want.st == ST_WZERO) n_wzero++;
      end
      checked++;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || rst)
      idle_cycles <= 0;
    else if (pending_vertices.size() != 0 || in_valid || expected_xforms.size() != 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_xforms.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    matrix_regs[0] = {32'd0, ELEM_ONE};
    matrix_regs[1] = '0;
    matrix_regs[2] = {ELEM_ONE, 32'd0};
    matrix_regs[3] = '0;
    matrix_regs[4] = '0;
    matrix_regs[5] = {32'd0, ELEM_ONE};
    matrix_regs[6] = '0;
    matrix_regs[7] = {ELEM_ONE, 32'd0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: identity matrix, field extremes, both modes.
    push_vertex(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000);
    push_vertex(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    push_vertex(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_vertex(1'b1, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
    wait_drained();

    // Directed: w scaled by z, giving zero w, negative w and overflowing quotients.
    apb_write(7, '0);
    apb_write(5, {32'h0001_0000, 32'h0001_0000});
    push_vertex(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0);
    push_vertex(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    push_vertex(1'b0, 32'h0003_0000, 32'h0001_0000, 32'hFFFE_0000);
    push_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0100);
    push_vertex(1'b1, 32'h1234_5678, 32'h8765_4321, 32'h0);
    wait_drained();

    // Directed: all-extreme matrix to force every saturation.
    for (int i = 0; i < NREG; i++) apb_write(i, {32'h7FFF_FFFF, 32'h8000_0000});
    push_vertex(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_vertex(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vertex(1'b0, 32'h0, 32'h0, 32'h0);
    wait_drained();
    for (int i = 0; i < NREG; i++) apb_write(i, '1);
    push_vertex(1'b0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_vertex(1'b1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0);
    wait_drained();
    for (int i = 0; i < NREG; i++) apb_write(i, '0);
    push_vertex(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    push_vertex(1'b1, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    wait_drained();

    // Random phases across several matrix settings.
    for (int ph = 0; ph < 10; ph++) begin
      load_random_matrix(ph % 3 == 2);
      random_batch(183);
      wait_drained();
    end

    $display("Checked %0d vertex transfers over 15 matrix settings: %0d saturated, %0d zero-w.",
             checked, n_sat, n_wzero);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
